// File: design/timed_position_history_interp_assert.svh
// Assertion helpers used by tphi_back. Clock aclk, reset aresetn.
`ifndef TIMED_POSITION_HISTORY_INTERP_ASSERT_SVH
`define TIMED_POSITION_HISTORY_INTERP_ASSERT_SVH

// same-cycle implication
`define TPHI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tphi check failed");

// next-cycle implication
`define TPHI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tphi check failed");

`endif

// File: design/tphi_pkg.sv
package tphi_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W  = 32;

    typedef struct packed {
        logic [POS_W-1:0]  z;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
        logic [TIME_W-1:0] time_value;
    } sample_t;

    typedef struct packed {
        logic    is_query;
        sample_t sample;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_KSEL,
        ST_DIV,
        ST_MUL,
        ST_ADD
    } state_t;

endpackage

// File: design/timed_position_history_interp.sv
// Position history with linear interpolation. A push (s_tuser low) stores a timestamped
// sample in a ring of HISTORY_DEPTH entries and yields no result; a query (s_tuser high)
// yields one result: the position at the given time, or found low with zeros if nothing
// is stored. A query with one sample stored or a time at or before the oldest sample
// returns the oldest sample, and one at or after the newest sample returns the newest;
// otherwise the block finds the first sample at or after the query time and interpolates
// between it and the sample before it: the sample memory's single read port walks the
// history one entry per cycle, a restoring divider makes one fraction bit per cycle
// (skipped when the fraction is 0 or 1), and one shared multiplier serves the three axes
// in turn. A two-entry queue behind the input register keeps taking items, until it is
// full, while a query runs or a result waits.
module timed_position_history_interp
    import tphi_pkg::*;
#(
    parameter int HISTORY_DEPTH = 512,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TIME_W+3*POS_W-1:0] s_tdata,  // time_value, in_x, in_y, in_z
    input  logic                      s_tuser,  // cmd
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [3*POS_W-1:0]        m_tdata,  // out_x, out_y, out_z
    output logic                      m_tuser   // found
);

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic [POS_W-1:0] x, y, z;

    tphi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    tphi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_pop   (q_pop)
    );

    tphi_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_found  (m_tuser),
        .m_x      (x),
        .m_y      (y),
        .m_z      (z)
    );

    assign m_tdata = {z, y, x};

endmodule

// File: design/tphi_front.sv
module tphi_front
    import tphi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TIME_W+3*POS_W-1:0] s_tdata,
    input  logic                      s_tuser,
    output logic                      q_valid,
    input  logic                      q_ready,
    output item_t                     q_item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // classify: tuser set means a query, otherwise a push
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.is_query          <= s_tuser;
            item_reg.sample.time_value <= s_tdata[TIME_W-1:0];
            item_reg.sample.x          <= s_tdata[TIME_W+POS_W-1:TIME_W];
            item_reg.sample.y          <= s_tdata[TIME_W+2*POS_W-1:TIME_W+POS_W];
            item_reg.sample.z          <= s_tdata[TIME_W+3*POS_W-1:TIME_W+2*POS_W];
        end
    end

endmodule

// File: design/tphi_queue.sv
module tphi_queue
    import tphi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item,
    input  logic  out_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: design/tphi_back.sv
module tphi_back
    import tphi_pkg::*;
#(
    parameter int HISTORY_DEPTH = 512,
    parameter int FRACTION_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    output logic [POS_W-1:0] m_x,
    output logic [POS_W-1:0] m_y,
    output logic [POS_W-1:0] m_z
);

`include "timed_position_history_interp_assert.svh"

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int FW  = FRACTION_BITS;
    localparam int KW  = FW + 1;
    localparam int DW  = TIME_W + 1;
    localparam int PW  = DW + KW + 1;
    localparam int NW  = $clog2(FW + 1);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] lg);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, lg};
        if (s >= (CW + 1)'(HISTORY_DEPTH)) begin
            s = s - (CW + 1)'(HISTORY_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pick(input sample_t s, input logic [1:0] ax);
        logic [POS_W-1:0] v;
        unique case (ax)
            2'd0:    v = s.x;
            2'd1:    v = s.y;
            default: v = s.z;
        endcase
        return v;
    endfunction

    sample_t mem [HISTORY_DEPTH];
    sample_t rd_data_reg;
    logic    wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0] t_reg, t_next;
    sample_t prev_reg, prev_next;
    sample_t b_reg, b_next;
    logic signed [DW-1:0] ab_reg, ab_next;
    logic signed [DW-1:0] ac_reg, ac_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [KW-1:0] k_reg, k_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic m_valid_reg, m_valid_next;
    logic found_reg, found_next;
    logic [POS_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;

    logic [TIME_W:0] rem2;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] rounded;
    logic [POS_W-1:0] lerp_val;

    assign m_valid = m_valid_reg;
    assign m_found = found_reg;
    assign m_x     = x_reg;
    assign m_y     = y_reg;
    assign m_z     = z_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= q_item.sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rem2     = {rem_reg, 1'b0};
    assign pos_a    = pick(prev_reg, axis_reg);
    assign pos_b    = pick(b_reg, axis_reg);
    assign diff     = $signed({pos_b[POS_W-1], pos_b}) - $signed({pos_a[POS_W-1], pos_a});
    assign rounded  = (prod_reg + (PW'(1) <<< (FW - 1))) >>> FW;
    assign lerp_val = pos_a + rounded[POS_W-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        idx_next     = idx_reg;
        t_next       = t_reg;
        prev_next    = prev_reg;
        b_next       = b_reg;
        ab_next      = ab_reg;
        ac_next      = ac_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        found_next   = found_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = slot_of(oldest_reg, count_reg);
        rd_addr      = slot_of(oldest_reg, '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && !q_item.is_query) begin
                    q_pop = 1'b1;
                    wr_en = 1'b1;
                    if (count_reg < CW'(HISTORY_DEPTH)) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        // full: overwrite the oldest and advance
                        wr_addr     = oldest_reg;
                        oldest_next = (oldest_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                    : oldest_reg + 1'b1;
                    end
                end else if (q_valid && !m_valid_reg) begin
                    q_pop  = 1'b1;
                    t_next = q_item.sample.time_value;
                    if (count_reg == '0) begin
                        found_next   = 1'b0;
                        x_next       = '0;
                        y_next       = '0;
                        z_next       = '0;
                        m_valid_next = 1'b1;
                    end else begin
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                prev_next = rd_data_reg;
                rd_addr   = slot_of(oldest_reg, count_reg - 1'b1);
                if (count_reg == CW'(1) || t_reg <= rd_data_reg.time_value) begin
                    found_next   = 1'b1;
                    x_next       = rd_data_reg.x;
                    y_next       = rd_data_reg.y;
                    z_next       = rd_data_reg.z;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (t_reg >= rd_data_reg.time_value) begin
                    found_next   = 1'b1;
                    x_next       = rd_data_reg.x;
                    y_next       = rd_data_reg.y;
                    z_next       = rd_data_reg.z;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    idx_next   = CW'(1);
                    rd_addr    = slot_of(oldest_reg, CW'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one entry per cycle; the newest sample guarantees a hit
                rd_addr = slot_of(oldest_reg, idx_reg + 1'b1);
                if (rd_data_reg.time_value >= t_reg) begin
                    b_next     = rd_data_reg;
                    ab_next    = $signed({1'b0, rd_data_reg.time_value})
                               - $signed({1'b0, prev_reg.time_value});
                    ac_next    = $signed({1'b0, t_reg}) - $signed({1'b0, prev_reg.time_value});
                    state_next = ST_KSEL;
                end else begin
                    prev_next = rd_data_reg;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_KSEL: begin
                axis_next = 2'd0;
                if (ab_reg <= 0 || ac_reg <= 0) begin
                    k_next     = '0;
                    state_next = ST_MUL;
                end else if (ac_reg >= ab_reg) begin
                    k_next     = KW'(1) << FW;
                    state_next = ST_MUL;
                end else begin
                    rem_next   = ac_reg[TIME_W-1:0];
                    k_next     = '0;
                    cnt_next   = NW'(FW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem2 >= ab_reg[DW-1:0]) begin
                    rem_next = rem2[TIME_W-1:0] - ab_reg[TIME_W-1:0];
                    k_next   = {k_reg[KW-2:0], 1'b1};
                end else begin
                    rem_next = rem2[TIME_W-1:0];
                    k_next   = {k_reg[KW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == NW'(1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = $signed({{(PW - DW){diff[DW-1]}}, diff})
                           * $signed({{(PW - KW){1'b0}}, k_reg});
                state_next = ST_ADD;
            end
            ST_ADD: begin
                unique case (axis_reg)
                    2'd0:    x_next = lerp_val;
                    2'd1:    y_next = lerp_val;
                    default: z_next = lerp_val;
                endcase
                if (axis_reg == 2'd2) begin
                    found_next   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        t_reg     <= t_next;
        prev_reg  <= prev_next;
        b_reg     <= b_next;
        ab_reg    <= ab_next;
        ac_reg    <= ac_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        axis_reg  <= axis_next;
        prod_reg  <= prod_next;
        found_reg <= found_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
    end

    `TPHI_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(HISTORY_DEPTH))
    `TPHI_ASSERT_IMPL(a_oldest_full, oldest_reg != '0, count_reg == CW'(HISTORY_DEPTH))
    `TPHI_ASSERT_IMPL(a_div_range, state_reg == ST_DIV,
                      ab_reg > 0 && ac_reg > 0 && ac_reg < ab_reg)
    `TPHI_ASSERT_NEXT(a_query_blocks, state_reg != ST_IDLE, !q_pop || state_reg == ST_IDLE)

endmodule
